/* rtl/pcd_pkg.sv */
// Package for the pulse interval code detector.
// Holds the register indexes, reset values, saturation limits and the
// configuration struct. No dependencies.
`timescale 1ns / 1ps

package pcd_pkg;

    localparam int RUN_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_QUIET_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_QUIET_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN_RUN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_OFFSET   = 3'd4;

    localparam logic [15:0] QUIET_THRESHOLD_RST   = 16'd1600;
    localparam logic [7:0]  LONG_QUIET_LIMIT_RST  = 8'd20;
    localparam logic [7:0]  SHORT_QUIET_LIMIT_RST = 8'd3;
    localparam logic [7:0]  PULSE_MIN_RUN_RST     = 8'd3;
    localparam logic [7:0]  INTERVAL_OFFSET_RST   = 8'd6;

    localparam int          LEN_W     = 17;
    localparam int          OUT_RUN_W = 16;
    localparam logic [7:0]  TALLY_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] quiet_threshold;
        logic [7:0]  long_quiet_limit;
        logic [7:0]  short_quiet_limit;
        logic [7:0]  pulse_min_run;
        logic [7:0]  interval_offset;
    } t_cfg;

endpackage

/* rtl/pcd_in_if.sv */
// Input channel of the detector: one signed audio sample per item.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface pcd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/pcd_out_if.sv */
// Result channel of the detector: counts and flags for each item.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface pcd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  interval_count;
    logic [16:0] first_interval_length;
    logic [15:0] quiet_run_out;
    logic [15:0] pulse_run_out;
    logic        is_pulse;
    logic        interval_closed;

    modport source (output valid, output interval_count, output first_interval_length,
                    output quiet_run_out, output pulse_run_out, output is_pulse,
                    output interval_closed, input ready);
    modport sink   (input valid, input interval_count, input first_interval_length,
                    input quiet_run_out, input pulse_run_out, input is_pulse,
                    input interval_closed, output ready);
endinterface

/* rtl/pcd_front.sv */
// Front stage: accepts samples, takes the magnitude and classifies it
// against the quiet threshold. Uses pcd_pkg and pcd_in_if.
`timescale 1ns / 1ps

module pcd_front import pcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_quiet_threshold,
    pcd_in_if.sink      i_in,
    output logic        o_push,
    output logic        o_pulse,
    input  logic        i_push_ready
);

    logic        r_valid;
    logic        n_valid;
    logic        r_pulse;
    logic [16:0] mag;
    logic        take;

    // Most negative sample gives 32768, one past the positive range.
    always_comb begin
        if (i_in.sample[15]) begin
            mag = 17'h10000 - {1'b0, i_in.sample};
        end else begin
            mag = {1'b0, i_in.sample};
        end
    end

    assign i_in.ready = !r_valid || i_push_ready;
    assign take       = i_in.valid && i_in.ready;
    assign o_push     = r_valid;
    assign o_pulse    = r_pulse;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pulse <= !(mag < {1'b0, i_quiet_threshold});
        end
    end

endmodule

/* rtl/pcd_queue.sv */
// Two-entry queue of classified items between front and back.
// Register based; no package dependency.
`timescale 1ns / 1ps

module pcd_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_data,
    output logic o_ready,
    output logic o_valid,
    output logic o_data,
    input  logic i_pop
);

    logic       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/pcd_back.sv */
// Back stage: run counters, interval tally, first interval latch and the
// result register. Uses pcd_pkg and pcd_out_if.
`timescale 1ns / 1ps

module pcd_back import pcd_pkg::*; #(
    parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  logic      i_q_pulse,
    output logic      o_q_pop,
    pcd_out_if.source o_out
);

    localparam int LW = (RUN_WIDTH + 1 > LEN_W) ? RUN_WIDTH + 1 : LEN_W;
    localparam int CW = (RUN_WIDTH > OUT_RUN_W) ? RUN_WIDTH : OUT_RUN_W;
    localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

    logic [RUN_WIDTH-1:0] r_quiet;
    logic [RUN_WIDTH-1:0] n_quiet;
    logic [RUN_WIDTH-1:0] r_prun;
    logic [RUN_WIDTH-1:0] n_prun;
    logic [7:0]           r_tally;
    logic [7:0]           n_tally;
    logic [LEN_W-1:0]     r_first;
    logic [LEN_W-1:0]     n_first;
    logic                 n_closed;
    logic                 r_ov;

    logic [RUN_WIDTH-1:0] quiet_inc;
    logic [RUN_WIDTH-1:0] prun_inc;
    logic [RUN_WIDTH-1:0] long_lim;
    logic [RUN_WIDTH-1:0] short_lim;
    logic [RUN_WIDTH-1:0] pmin;
    logic [LW-1:0]        len;
    logic [CW-1:0]        quiet_x;
    logic [CW-1:0]        prun_x;

    assign o_q_pop = i_q_valid && (!r_ov || o_out.ready);

    assign quiet_inc = (r_quiet == RUN_MAX) ? RUN_MAX : r_quiet + 1'b1;
    assign prun_inc  = (r_prun == RUN_MAX) ? RUN_MAX : r_prun + 1'b1;
    assign long_lim  = RUN_WIDTH'(i_cfg.long_quiet_limit);
    assign short_lim = RUN_WIDTH'(i_cfg.short_quiet_limit);
    assign pmin      = RUN_WIDTH'(i_cfg.pulse_min_run);
    assign len       = LW'(r_quiet) + LW'(i_cfg.interval_offset);

    always_comb begin
        n_quiet  = r_quiet;
        n_prun   = r_prun;
        n_tally  = r_tally;
        n_first  = r_first;
        n_closed = 1'b0;
        if (!i_q_pulse) begin
            n_quiet = quiet_inc;
            if (quiet_inc > long_lim) begin
                n_tally = 8'd0;
            end
            if (quiet_inc > long_lim || quiet_inc > short_lim) begin
                n_prun = '0;
            end
        end else begin
            n_prun = prun_inc;
            if (prun_inc > pmin) begin
                if (r_quiet > short_lim) begin
                    // Second counted interval latches the first one's length.
                    if (r_tally == 8'd1) begin
                        n_first = (len > LW'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                              : len[LEN_W-1:0];
                    end
                    if (r_tally != TALLY_MAX) begin
                        n_tally = r_tally + 8'd1;
                    end
                    n_closed = 1'b1;
                end
                n_quiet = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet <= '0;
            r_prun  <= '0;
            r_tally <= 8'd0;
            r_first <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_quiet <= n_quiet;
                r_prun  <= n_prun;
                r_tally <= n_tally;
                r_first <= n_first;
                r_ov    <= 1'b1;
            end else if (o_out.ready) begin
                r_ov    <= 1'b0;
            end
        end
    end

    assign quiet_x = CW'(n_quiet);
    assign prun_x  = CW'(n_prun);

    // Result register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_out.interval_count        <= n_tally;
            o_out.first_interval_length <= n_first;
            o_out.quiet_run_out   <= (quiet_x > CW'({OUT_RUN_W{1'b1}})) ? {OUT_RUN_W{1'b1}}
                                                                       : quiet_x[OUT_RUN_W-1:0];
            o_out.pulse_run_out   <= (prun_x > CW'({OUT_RUN_W{1'b1}})) ? {OUT_RUN_W{1'b1}}
                                                                      : prun_x[OUT_RUN_W-1:0];
            o_out.is_pulse        <= i_q_pulse;
            o_out.interval_closed <= n_closed;
        end
    end

    assign o_out.valid = r_ov;

    a_closed_is_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && o_out.interval_closed |-> o_out.is_pulse)
        else $error("interval closed on a quiet item");

    a_closed_clears_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && o_out.interval_closed |-> o_out.quiet_run_out == '0 &&
                                          o_out.interval_count != 8'd0)
        else $error("closed interval left quiet run or tally wrong");

    a_pulse_run_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && o_out.is_pulse |-> o_out.pulse_run_out != '0)
        else $error("pulse item reports empty pulse run");

    a_quiet_run_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.is_pulse |-> o_out.quiet_run_out != '0)
        else $error("quiet item reports empty quiet run");

endmodule

/* rtl/pulse_interval_code_detector_top.sv */
// Top level of the pulse interval code detector: configuration registers,
// front classifier, queue and back counter stage. Uses pcd_pkg, pcd_in_if,
// pcd_out_if, pcd_front, pcd_queue and pcd_back.
//
//   channel   dir  handshake        payload
//   i_in      in   valid / ready    sample (signed 16)
//   o_out     out  valid / ready    interval_count, first_interval_length,
//                                   quiet_run_out, pulse_run_out, is_pulse,
//                                   interval_closed
//   i_cfg_*   in   write enable     index 3 bits, data 16 bits
//
// One item per cycle sustained while o_out is ready; each result passes through
// the classify register, the queue and the result register. The counter
// update in the back stage sets the cycle time. Synchronous active-low reset
// clears control state and loads the register defaults. A stalled output
// fills the result register, the queue and the classify register, then drops
// ready.
`timescale 1ns / 1ps

module pulse_interval_code_detector_top import pcd_pkg::*; #(
    parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcd_in_if.sink                i_in,
    pcd_out_if.source             o_out
);

    t_cfg r_cfg;
    logic push;
    logic push_pulse;
    logic push_ready;
    logic q_valid;
    logic q_pulse;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quiet_threshold   <= QUIET_THRESHOLD_RST;
            r_cfg.long_quiet_limit  <= LONG_QUIET_LIMIT_RST;
            r_cfg.short_quiet_limit <= SHORT_QUIET_LIMIT_RST;
            r_cfg.pulse_min_run     <= PULSE_MIN_RUN_RST;
            r_cfg.interval_offset   <= INTERVAL_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUIET_THRESHOLD:   r_cfg.quiet_threshold   <= i_cfg_data;
                CFG_LONG_QUIET_LIMIT:  r_cfg.long_quiet_limit  <= i_cfg_data[7:0];
                CFG_SHORT_QUIET_LIMIT: r_cfg.short_quiet_limit <= i_cfg_data[7:0];
                CFG_PULSE_MIN_RUN:     r_cfg.pulse_min_run     <= i_cfg_data[7:0];
                CFG_INTERVAL_OFFSET:   r_cfg.interval_offset   <= i_cfg_data[7:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    pcd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_quiet_threshold (r_cfg.quiet_threshold),
        .i_in              (i_in),
        .o_push            (push),
        .o_pulse           (push_pulse),
        .i_push_ready      (push_ready)
    );

    pcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_pulse),
        .o_ready (push_ready),
        .o_valid (q_valid),
        .o_data  (q_pulse),
        .i_pop   (q_pop)
    );

    pcd_back #(
        .RUN_WIDTH (RUN_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_pulse (q_pulse),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

/* bench/tb_pulse_interval_code_detector_top.sv */
// Self-checking bench for the pulse interval code detector top level.
// Depends on pcd_pkg, pcd_in_if, pcd_out_if and the detector RTL; predicts
// every result in step with accepted samples and checks it field by field.
`timescale 1ns / 1ps

module tb_pulse_interval_code_detector_top;
    import pcd_pkg::*;

    localparam int           LIMIT_CYCLES    = 1_500_000;
    localparam int           DRAIN_CYCLES    = 8;
    localparam int           LONG_HOLD       = 400;
    localparam int           RANDOM_PHASES   = 8;
    localparam int           ITEMS_PER_PHASE = 60;
    localparam int           HOLD_PHASE      = 5;
    localparam int           JUNK_PHASE      = 6;
    localparam int           CFG_UNUSED_LO   = 5;
    localparam int           CFG_IDX_COUNT   = 1 << CFG_IDX_W;
    localparam int           SAT_PAIRS       = 300;
    localparam logic [15:0]  RUN_MAX         = '1;

    typedef struct {
        logic [7:0]  interval_count;
        logic [16:0] first_len;
        logic [15:0] quiet_run;
        logic [15:0] pulse_run;
        logic        is_pulse;
        logic        interval_closed;
    } t_counts;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [2:0]        cfg_idx    = '0;
    logic [15:0]       cfg_data   = '0;
    logic              smp_valid  = 1'b0;
    logic [15:0]       smp_data   = '0;
    logic              res_ready  = 1'b0;

    int                smp_wait   = 0;
    int                res_wait   = 0;
    int                hold_left  = 0;
    int                hold_reqs  = 0;
    int                hold_seen  = 0;
    bit                in_no_idle  = 1'b0;
    bit                out_no_idle = 1'b0;
    int                mismatches = 0;
    int                cycle_count = 0;

    logic [15:0]       sample_backlog[$];
    t_counts           expected_counts[$];

    // detector state as predicted
    t_cfg              settings;
    logic [15:0]       run_quiet;
    logic [15:0]       run_pulse;
    logic [7:0]        tally;
    logic [16:0]       first_len;

    pcd_in_if  u_in_bus ();
    pcd_out_if u_out_bus ();

    assign u_in_bus.valid  = smp_valid;
    assign u_in_bus.sample = smp_data;
    assign u_out_bus.ready = res_ready;

    pulse_interval_code_detector_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (u_in_bus),
        .o_out      (u_out_bus)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int draw_wait(input bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 12));
    endfunction

    task automatic advance_detector(input logic [15:0] raw);
        logic [16:0] mag;
        t_counts     want;
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        want.is_pulse = (mag >= {1'b0, settings.quiet_threshold});
        want.interval_closed = 1'b0;
        if (!want.is_pulse) begin
            if (run_quiet != RUN_MAX) run_quiet = run_quiet + 1'b1;
            if (run_quiet > settings.long_quiet_limit) begin
                tally = '0;
                run_pulse = '0;
            end
            if (run_quiet > settings.short_quiet_limit) run_pulse = '0;
        end else begin
            if (run_pulse != RUN_MAX) run_pulse = run_pulse + 1'b1;
            if (run_pulse > settings.pulse_min_run) begin
                if (run_quiet > settings.short_quiet_limit) begin
                    if (tally == 8'd1)
                        first_len = {1'b0, run_quiet} + settings.interval_offset;
                    if (tally != TALLY_MAX) tally = tally + 1'b1;
                    want.interval_closed = 1'b1;
                end
                run_quiet = '0;
            end
        end
        want.interval_count = tally;
        want.first_len = first_len;
        want.quiet_run = run_quiet;
        want.pulse_run = run_pulse;
        expected_counts.push_back(want);
    endtask

    task automatic check_result();
        t_counts want;
        if (expected_counts.size() == 0) begin
            report_mismatch("result with nothing pending, quiet_run", u_out_bus.quiet_run_out, 0);
            return;
        end
        want = expected_counts.pop_front();
        if (u_out_bus.interval_count !== want.interval_count)
            report_mismatch("interval_count", u_out_bus.interval_count, want.interval_count);
        if (u_out_bus.first_interval_length !== want.first_len)
            report_mismatch("first_interval_length", u_out_bus.first_interval_length,
                            want.first_len);
        if (u_out_bus.quiet_run_out !== want.quiet_run)
            report_mismatch("quiet_run_out", u_out_bus.quiet_run_out, want.quiet_run);
        if (u_out_bus.pulse_run_out !== want.pulse_run)
            report_mismatch("pulse_run_out", u_out_bus.pulse_run_out, want.pulse_run);
        if (u_out_bus.is_pulse !== want.is_pulse)
            report_mismatch("is_pulse", u_out_bus.is_pulse, want.is_pulse);
        if (u_out_bus.interval_closed !== want.interval_closed)
            report_mismatch("interval_closed", u_out_bus.interval_closed, want.interval_closed);
    endtask

    // sample driver
    always @(posedge i_clk) begin : drive_samples
        int gap;
        if (!i_rst_n) begin
            smp_valid <= 1'b0;
            smp_wait  <= 0;
        end else if (smp_valid && u_in_bus.ready) begin
            advance_detector(smp_data);
            gap = draw_wait(in_no_idle);
            if (gap == 0 && sample_backlog.size() > 0) begin
                smp_data <= sample_backlog.pop_front();
            end else begin
                smp_valid <= 1'b0;
                smp_wait  <= gap;
            end
        end else if (!smp_valid) begin
            if (smp_wait > 0) begin
                smp_wait <= smp_wait - 1;
            end else if (sample_backlog.size() > 0) begin
                smp_valid <= 1'b1;
                smp_data  <= sample_backlog.pop_front();
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : collect_results
        int stall;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            res_wait  <= 0;
            hold_left <= 0;
        end else begin
            if (u_out_bus.valid && res_ready) check_result();
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_ready <= 1'b0;
            end else if (hold_reqs != hold_seen) begin
                hold_seen <= hold_reqs;
                hold_left <= LONG_HOLD;
                res_ready <= 1'b0;
            end else if (u_out_bus.valid && res_ready) begin
                stall = draw_wait(out_no_idle);
                res_wait  <= stall;
                res_ready <= (stall == 0);
            end else if (res_wait > 0) begin
                res_wait  <= res_wait - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic store_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_QUIET_THRESHOLD:   settings.quiet_threshold   = data;
            CFG_LONG_QUIET_LIMIT:  settings.long_quiet_limit  = data[7:0];
            CFG_SHORT_QUIET_LIMIT: settings.short_quiet_limit = data[7:0];
            CFG_PULSE_MIN_RUN:     settings.pulse_min_run     = data[7:0];
            CFG_INTERVAL_OFFSET:   settings.interval_offset   = data[7:0];
            default: ;
        endcase
    endtask

    // write enable stays high across back-to-back writes; close_writes drops it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        store_reg(idx, data);
    endtask

    task automatic close_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic write_settings(input t_cfg c);
        write_reg(CFG_QUIET_THRESHOLD, c.quiet_threshold);
        write_reg(CFG_LONG_QUIET_LIMIT, {8'($urandom), c.long_quiet_limit});
        write_reg(CFG_SHORT_QUIET_LIMIT, {8'($urandom), c.short_quiet_limit});
        write_reg(CFG_PULSE_MIN_RUN, {8'($urandom), c.pulse_min_run});
        write_reg(CFG_INTERVAL_OFFSET, {8'($urandom), c.interval_offset});
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_backlog.size() != 0 || smp_valid || expected_counts.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_cfg pick_settings(input int phase);
        t_cfg c;
        c.quiet_threshold   = 16'($urandom_range(200, 6000));
        c.long_quiet_limit  = 8'($urandom_range(4, 40));
        c.short_quiet_limit = 8'($urandom_range(0, 6));
        c.pulse_min_run     = 8'($urandom_range(0, 6));
        c.interval_offset   = 8'($urandom);
        case (phase)
            0: c.quiet_threshold = 16'd0;
            1: c.quiet_threshold = 16'd32768;
            2: c.quiet_threshold = 16'($urandom_range(32769, 65535));
            3: begin
                c.long_quiet_limit  = 8'd0;
                c.short_quiet_limit = 8'd0;
                c.pulse_min_run     = 8'd0;
                c.interval_offset   = 8'd0;
            end
            4: begin
                c.long_quiet_limit  = 8'd255;
                c.short_quiet_limit = 8'd255;
                c.pulse_min_run     = 8'd255;
                c.interval_offset   = 8'd255;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] signed_of(input int unsigned mag, input bit neg);
        return neg ? 16'(17'h10000 - mag) : 16'(mag);
    endfunction

    function automatic logic [15:0] quiet_sample();
        int unsigned thr, top, m;
        thr = settings.quiet_threshold;
        if (thr == 0) return 16'($urandom);
        top = (thr - 1 > 32768) ? 32768 : thr - 1;
        m = ($urandom_range(0, 3) == 0) ? top : $urandom_range(0, top);
        return signed_of(m, (m == 32768) ? 1'b1 : 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [15:0] pulse_sample();
        int unsigned thr, m;
        thr = settings.quiet_threshold;
        if (thr > 32768) return 16'($urandom);
        m = ($urandom_range(0, 3) == 0) ? thr : $urandom_range(thr, 32768);
        return signed_of(m, (m == 32768) ? 1'b1 : 1'($urandom_range(0, 1)));
    endfunction

    function automatic int quiet_len();
        int s, l;
        s = settings.short_quiet_limit;
        l = settings.long_quiet_limit;
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, s + 1);
            1: return s + $urandom_range(1, 2);
            2: return (l > 1 ? l - 1 : 1) + $urandom_range(0, 3);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int pulse_len();
        int p;
        p = settings.pulse_min_run;
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, p + 2);
            1: return p + 1;
            2: return $urandom_range(1, 8);
            default: return p + $urandom_range(1, 3);
        endcase
    endfunction

    // mostly quiet gap followed by a pulse burst, the rest raw noise
    task automatic add_random_items(input int budget);
        int added, n;
        added = 0;
        while (added < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                n = quiet_len();
                repeat (n) sample_backlog.push_back(quiet_sample());
                added += n;
                n = pulse_len();
                repeat (n) sample_backlog.push_back(pulse_sample());
                added += n;
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) sample_backlog.push_back(16'($urandom));
                added += n;
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] opening[$];
        t_cfg        sat_cfg;
        settings.quiet_threshold   = QUIET_THRESHOLD_RST;
        settings.long_quiet_limit  = LONG_QUIET_LIMIT_RST;
        settings.short_quiet_limit = SHORT_QUIET_LIMIT_RST;
        settings.pulse_min_run     = PULSE_MIN_RUN_RST;
        settings.interval_offset   = INTERVAL_OFFSET_RST;
        run_quiet = '0;
        run_pulse = '0;
        tally     = '0;
        first_len = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes, threshold edges, an unqualified pulse,
        // a counted interval, then a second one that latches the length
        opening = '{16'd0, 16'd32767, 16'h8000, -16'd1599, 16'd1600, -16'd1600,
                    16'd0, 16'd1, -16'd1, 16'd1599, -16'd1599,
                    16'd1600, 16'h8000, 16'd32767, -16'd1600,
                    16'd2, -16'd2, 16'd100, -16'd100, 16'd1598,
                    16'd1601, -16'd1601, 16'd20000, -16'd20000};
        @(negedge i_clk);
        foreach (opening[k]) sample_backlog.push_back(opening[k]);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_settings(pick_settings(phase));
            if (phase == JUNK_PHASE)
                for (int k = CFG_UNUSED_LO; k < CFG_IDX_COUNT; k++)
                    write_reg(3'(k), 16'($urandom));
            close_writes();
            @(negedge i_clk);
            in_no_idle  = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            out_no_idle = ($urandom_range(0, 3) == 0);
            add_random_items(ITEMS_PER_PHASE);
            if (phase == HOLD_PHASE) hold_reqs++;
            wait_idle();
        end

        // saturate the tally at full rate
        sat_cfg.quiet_threshold   = QUIET_THRESHOLD_RST;
        sat_cfg.long_quiet_limit  = 8'd255;
        sat_cfg.short_quiet_limit = 8'd0;
        sat_cfg.pulse_min_run     = 8'd0;
        sat_cfg.interval_offset   = 8'd255;
        write_settings(sat_cfg);
        close_writes();
        @(negedge i_clk);
        in_no_idle  = 1'b1;
        out_no_idle = 1'b1;
        repeat (SAT_PAIRS) begin
            sample_backlog.push_back(quiet_sample());
            sample_backlog.push_back(pulse_sample());
        end
        repeat (5) sample_backlog.push_back(quiet_sample());
        wait_idle();

        if (expected_counts.size() != 0)
            report_mismatch("results never arrived", 0, expected_counts.size());
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
